// ===== rtl/ggxh_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ggxh_pkg: shared types and constants of the GGX half vector sampler
// Fixed point formats, series reciprocals, cell link types and output helpers.
// ----------------------------------------------------------------------------
package ggxh_pkg;

   // unity in the working format (16 fraction bits)
   localparam logic [16:0] ONE_W = 17'h10000;

   // largest n2 kept, 4 - 2^-16
   localparam logic [17:0] SAT_N2 = 18'h3FFFF;

   // pi/2 with 48 fraction bits, split for two narrow products
   localparam logic [48:0] PI_HALF_Q48 = 49'h1921FB54442D1;
   localparam logic [18:0] PI_HI = PI_HALF_Q48[48:30];
   localparam logic [29:0] PI_LO = PI_HALF_Q48[29:0];

   localparam int HORNER_CELLS = 6;
   localparam int SQRT_CELLS   = 17;
   localparam int DIV_CELLS    = 18;

   // ceil(2^32 / d) for the Horner divisors; sine uses one step fewer,
   // a zero reciprocal leaves its term at one in the first cell
   localparam logic [31:0] SIN_RECIP [HORNER_CELLS] = '{
      32'd0, 32'd39045158, 32'd59652324, 32'd102261127, 32'd214748365, 32'd715827883
   };
   localparam logic [31:0] COS_RECIP [HORNER_CELLS] = '{
      32'd32537632, 32'd47721859, 32'd76695845, 32'd143165577, 32'd357913942,
      32'd2147483648
   };

   // quadrant codes from the top bits of u
   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;

   typedef struct packed {
      logic [16:0] ts;
      logic [16:0] tc;
      logic [15:0] y2;
   } horner_type;

   typedef struct packed {
      logic [17:0] rem;
      logic [16:0] root;
      logic [33:0] x;
   } sqrt_type;

   typedef struct packed {
      logic [18:0] rem;
      logic [17:0] nb;
      logic [17:0] quot;
      logic [18:0] den;
   } div_type;

   typedef struct packed {
      logic [1:0]  quad;
      logic        swap;
      logic [16:0] axw;
      logic [16:0] ayw;
      logic [15:0] v;
      logic [32:0] pp_hi;
      logic [43:0] pp_lo;
      logic [15:0] y;
      logic [15:0] y2;
      logic [16:0] sy;
      logic [16:0] cy;
      logic [16:0] cm;
      logic [16:0] sm;
      logic        cneg;
      logic        sneg;
      logic [16:0] px;
      logic [16:0] py;
      logic [17:0] px2;
      logic [17:0] py2;
      logic [17:0] n2;
      logic [18:0] den;
      logic        nzero;
      logic [16:0] cn;
      logic [16:0] sn;
      logic [16:0] cos2;
      logic [16:0] ct;
      logic [16:0] st2;
      logic [15:0] hx;
      logic [15:0] hy;
      logic [14:0] hz;
   } side_type;

   function automatic logic [16:0] clamp_one(input logic [17:0] x);
      logic [16:0] r;
      if (x > {1'b0, ONE_W}) begin
         r = ONE_W;
      end else begin
         r = x[16:0];
      end
      return r;
   endfunction

   // Q1.16 magnitude to Q1.15 two's complement, saturated at 32767
   function automatic logic [15:0] to_out(input logic [16:0] mag, input logic neg);
      logic [15:0] m;
      m = mag[16:1];
      if (m > 16'd32767) begin
         m = 16'd32767;
      end
      if (neg && m != 16'd0) begin
         m = 16'd0 - m;
      end
      return m;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/ggxh_horner_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ggxh_horner_cell: one Horner step of the sine and cosine series
// Two register stages: t*y2 product, then division by reciprocal product.
// ----------------------------------------------------------------------------
module ggxh_horner_cell (
   input  wire logic                 clock,
   input  wire logic                 en,
   input  wire logic [31:0]          sin_recip,
   input  wire logic [31:0]          cos_recip,
   input  wire ggxh_pkg::horner_type din,
   output ggxh_pkg::horner_type      dout
);

   logic [15:0] ps_ff, ps_in, pc_ff, pc_in, y2_ff, y2_in;
   logic [32:0] ps_prod, pc_prod;
   logic [47:0] qs_prod, qc_prod;
   ggxh_pkg::horner_type out_ff, out_in;

   always_comb begin
      ps_prod = 33'(din.y2) * 33'(din.ts);
      pc_prod = 33'(din.y2) * 33'(din.tc);
      ps_in   = ps_prod[31:16];
      pc_in   = pc_prod[31:16];
      y2_in   = din.y2;
      qs_prod = 48'(ps_ff) * 48'(sin_recip);
      qc_prod = 48'(pc_ff) * 48'(cos_recip);
      out_in.ts = ggxh_pkg::ONE_W - {1'b0, qs_prod[47:32]};
      out_in.tc = ggxh_pkg::ONE_W - {1'b0, qc_prod[47:32]};
      out_in.y2 = y2_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ps_ff  <= ps_in;
         pc_ff  <= pc_in;
         y2_ff  <= y2_in;
         out_ff <= out_in;
      end
   end

   assign dout = out_ff;

endmodule
`default_nettype wire

// ===== rtl/ggxh_sqrt_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ggxh_sqrt_cell: one root bit of a restoring integer square root
// Brings down two radicand bits and tries root*4+1 against the remainder.
// ----------------------------------------------------------------------------
module ggxh_sqrt_cell (
   input  wire logic               clock,
   input  wire logic               en,
   input  wire ggxh_pkg::sqrt_type din,
   output ggxh_pkg::sqrt_type      dout
);

   logic [19:0] r4, trial, diff;
   logic        ge;
   ggxh_pkg::sqrt_type out_ff, out_in;

   always_comb begin
      r4    = {din.rem, din.x[33:32]};
      trial = {1'b0, din.root, 2'b01};
      ge    = r4 >= trial;
      diff  = r4 - trial;
      out_in.rem  = ge ? diff[17:0] : r4[17:0];
      out_in.root = {din.root[15:0], ge};
      out_in.x    = {din.x[31:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= out_in;
      end
   end

   assign dout = out_ff;

endmodule
`default_nettype wire

// ===== rtl/ggxh_div_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ggxh_div_cell: one quotient bit of a restoring divider
// Shifts in the next numerator bit and subtracts the divisor when it fits.
// ----------------------------------------------------------------------------
module ggxh_div_cell (
   input  wire logic              clock,
   input  wire logic              en,
   input  wire ggxh_pkg::div_type din,
   output ggxh_pkg::div_type      dout
);

   logic [19:0] r2, dext, diff;
   logic        ge;
   ggxh_pkg::div_type out_ff, out_in;

   always_comb begin
      r2   = {din.rem, din.nb[17]};
      dext = {1'b0, din.den};
      ge   = r2 >= dext;
      diff = r2 - dext;
      out_in.rem  = ge ? diff[18:0] : r2[18:0];
      out_in.nb   = {din.nb[16:0], 1'b0};
      out_in.quot = {din.quot[16:0], ge};
      out_in.den  = din.den;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= out_in;
      end
   end

   assign dout = out_ff;

endmodule
`default_nettype wire

// ===== rtl/ggx_anisotropic_half_vector_sampler_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ggx_anisotropic_half_vector_sampler_unit: anisotropic GGX half vector sampler
// Maps two uniform samples and two roughness values to a unit half vector.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel req_*: u, v samples (Q0.16) and roughness x, y (Q1.15).
//    A transfer happens on a clock edge with req_valid high, req_stall low.
//  - Result channel rsp_*: half vector x, y (signed Q1.15) and z (unsigned Q0.15).
//  - Fully pipelined: one transfer per cycle sustained while the result
//    is not stalled. Depth is set by the chains of cells: six two-stage
//    Horner cells for sine/cosine, three 17-cell square root chains,
//    three side-by-side 18-cell divider rows, plus ten datapath stages.
//  - A stalled result holds the whole pipeline; req_stall follows it in the
//    same cycle, so no transfer is lost while the receiver stalls.
//  - Synchronous reset empties the pipeline; payload registers keep data.
// ----------------------------------------------------------------------------
module ggx_anisotropic_half_vector_sampler_unit (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [15:0]        req_u_sample,
   input  wire logic [15:0]        req_v_sample,
   input  wire logic [15:0]        req_rough_x,
   input  wire logic [15:0]        req_rough_y,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [15:0]      rsp_half_x,
   output logic signed [15:0]      rsp_half_y,
   output logic [14:0]             rsp_half_z
);

   localparam int HC = ggxh_pkg::HORNER_CELLS;
   localparam int SC = ggxh_pkg::SQRT_CELLS;
   localparam int DC = ggxh_pkg::DIV_CELLS;

   localparam int ST_Y       = 1;
   localparam int ST_Y2      = 2;
   localparam int ST_HC      = 3;
   localparam int ST_SY      = ST_HC + 2 * HC;
   localparam int ST_PXY     = ST_SY + 1;
   localparam int ST_SQR     = ST_PXY + 1;
   localparam int ST_N2      = ST_SQR + 1;
   localparam int ST_RA      = ST_N2 + 1;
   localparam int ST_DV      = ST_RA + SC;
   localparam int ST_NORM    = ST_DV + DC;
   localparam int ST_RB      = ST_NORM + 1;
   localparam int ST_ST2     = ST_RB + SC;
   localparam int ST_RC      = ST_ST2 + 1;
   localparam int ST_OUT     = ST_RC + SC;
   localparam int PIPE_DEPTH = ST_OUT + 1;

   logic                  pipe_en;
   logic [PIPE_DEPTH-1:0] vld_ff, vld_in;
   ggxh_pkg::side_type    side_ff [PIPE_DEPTH];
   ggxh_pkg::side_type    side_in [PIPE_DEPTH];

   ggxh_pkg::horner_type  hc_link [HC+1];
   ggxh_pkg::sqrt_type    ra_link [SC+1];
   ggxh_pkg::sqrt_type    rb_link [SC+1];
   ggxh_pkg::sqrt_type    rc_link [SC+1];
   ggxh_pkg::div_type     dx_link [DC+1];
   ggxh_pkg::div_type     dy_link [DC+1];
   ggxh_pkg::div_type     dc_link [DC+1];

   logic [32:0] num_x, num_y, num_c;
   logic [16:0] omv_dv;

   // the pipeline only moves when the result register is free
   assign pipe_en   = !(vld_ff[ST_OUT] && rsp_stall);
   assign req_stall = !pipe_en;

   assign vld_in = {vld_ff[PIPE_DEPTH-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (pipe_en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         for (int i = 0; i < PIPE_DEPTH; i++) begin
            side_ff[i] <= side_in[i];
         end
      end
   end

   // chain heads
   assign num_x  = {side_ff[ST_DV-1].px, 16'h0};
   assign num_y  = {side_ff[ST_DV-1].py, 16'h0};
   assign omv_dv = ggxh_pkg::ONE_W - {1'b0, side_ff[ST_DV-1].v};
   assign num_c  = {omv_dv, 16'h0};

   assign hc_link[0] = '{ts: ggxh_pkg::ONE_W, tc: ggxh_pkg::ONE_W,
                         y2: side_ff[ST_HC-1].y2};
   assign ra_link[0] = '{rem: '0, root: '0, x: {side_ff[ST_RA-1].n2, 16'h0}};
   assign rb_link[0] = '{rem: '0, root: '0, x: {1'b0, side_ff[ST_RB-1].cos2, 16'h0}};
   assign rc_link[0] = '{rem: '0, root: '0, x: {1'b0, side_ff[ST_RC-1].st2, 16'h0}};
   assign dx_link[0] = '{rem: {4'b0, num_x[32:18]}, nb: num_x[17:0], quot: '0,
                         den: {2'b0, ra_link[SC].root}};
   assign dy_link[0] = '{rem: {4'b0, num_y[32:18]}, nb: num_y[17:0], quot: '0,
                         den: {2'b0, ra_link[SC].root}};
   assign dc_link[0] = '{rem: {4'b0, num_c[32:18]}, nb: num_c[17:0], quot: '0,
                         den: side_ff[ST_DV-1].den};

   for (genvar j = 0; j < HC; j++) begin : g_horner
      ggxh_horner_cell u_cell (
         .clock     (clock),
         .en        (pipe_en),
         .sin_recip (ggxh_pkg::SIN_RECIP[j]),
         .cos_recip (ggxh_pkg::COS_RECIP[j]),
         .din       (hc_link[j]),
         .dout      (hc_link[j+1])
      );
   end

   for (genvar j = 0; j < SC; j++) begin : g_sqrt
      ggxh_sqrt_cell u_ra (.clock(clock), .en(pipe_en), .din(ra_link[j]), .dout(ra_link[j+1]));
      ggxh_sqrt_cell u_rb (.clock(clock), .en(pipe_en), .din(rb_link[j]), .dout(rb_link[j+1]));
      ggxh_sqrt_cell u_rc (.clock(clock), .en(pipe_en), .din(rc_link[j]), .dout(rc_link[j+1]));
   end

   for (genvar j = 0; j < DC; j++) begin : g_div
      ggxh_div_cell u_dx (.clock(clock), .en(pipe_en), .din(dx_link[j]), .dout(dx_link[j+1]));
      ggxh_div_cell u_dy (.clock(clock), .en(pipe_en), .din(dy_link[j]), .dout(dy_link[j+1]));
      ggxh_div_cell u_dc (.clock(clock), .en(pipe_en), .din(dc_link[j]), .dout(dc_link[j+1]));
   end

   // per-stage datapath; everything else rides along unchanged
   always_comb begin
      logic [13:0]        r;
      logic [13:0]        rr;
      logic               swp;
      logic [14:0]        mir;
      logic [33:0]        ysum;
      logic [31:0]        ysq;
      logic [32:0]        sprod;
      ggxh_pkg::side_type s;
      logic [16:0]        cq, sq, cm, sm;
      logic               cneg, sneg;
      logic [33:0]        pxp, pyp, px2p, py2p, vn, ctsq, hxp, hyp;
      logic [18:0]        sum19;
      logic [16:0]        omv, ct;
      logic [15:0]        hz16;

      for (int i = 1; i < PIPE_DEPTH; i++) begin
         side_in[i] = side_ff[i-1];
      end

      // input: quadrant, mirror about pi/4, pi/2 * r in two partial products
      r   = req_u_sample[13:0];
      swp = r > 14'd8192;
      mir = 15'd16384 - {1'b0, r};
      rr  = swp ? mir[13:0] : r;
      side_in[0]       = '0;
      side_in[0].quad  = req_u_sample[15:14];
      side_in[0].swap  = swp;
      side_in[0].axw   = {req_rough_x, 1'b0};
      side_in[0].ayw   = {req_rough_y, 1'b0};
      side_in[0].v     = req_v_sample;
      side_in[0].pp_hi = 33'(rr) * 33'(ggxh_pkg::PI_HI);
      side_in[0].pp_lo = 44'(rr) * 44'(ggxh_pkg::PI_LO);

      ysum = 34'(side_ff[ST_Y-1].pp_hi) + 34'(side_ff[ST_Y-1].pp_lo[43:30]);
      side_in[ST_Y].y = ysum[31:16];

      ysq = 32'(side_ff[ST_Y2-1].y) * 32'(side_ff[ST_Y2-1].y);
      side_in[ST_Y2].y2 = ysq[31:16];

      sprod = 33'(side_ff[ST_SY-1].y) * 33'(hc_link[HC].ts);
      side_in[ST_SY].sy = sprod[32:16];
      side_in[ST_SY].cy = hc_link[HC].tc;

      // unfold the quadrant and scale by roughness
      s  = side_ff[ST_PXY-1];
      cq = s.swap ? s.sy : s.cy;
      sq = s.swap ? s.cy : s.sy;
      case (s.quad)
         ggxh_pkg::QUAD_0: begin
            cm = cq; cneg = 1'b0; sm = sq; sneg = 1'b0;
         end
         ggxh_pkg::QUAD_1: begin
            cm = sq; cneg = 1'b1; sm = cq; sneg = 1'b0;
         end
         ggxh_pkg::QUAD_2: begin
            cm = cq; cneg = 1'b1; sm = sq; sneg = 1'b1;
         end
         default: begin
            cm = sq; cneg = 1'b0; sm = cq; sneg = 1'b1;
         end
      endcase
      pxp = 34'(s.axw) * 34'(cm);
      pyp = 34'(s.ayw) * 34'(sm);
      side_in[ST_PXY].cm   = cm;
      side_in[ST_PXY].sm   = sm;
      side_in[ST_PXY].cneg = cneg;
      side_in[ST_PXY].sneg = sneg;
      side_in[ST_PXY].px   = pxp[32:16];
      side_in[ST_PXY].py   = pyp[32:16];

      px2p = 34'(side_ff[ST_SQR-1].px) * 34'(side_ff[ST_SQR-1].px);
      py2p = 34'(side_ff[ST_SQR-1].py) * 34'(side_ff[ST_SQR-1].py);
      side_in[ST_SQR].px2 = px2p[33:16];
      side_in[ST_SQR].py2 = py2p[33:16];

      sum19 = 19'(side_ff[ST_N2-1].px2) + 19'(side_ff[ST_N2-1].py2);
      side_in[ST_N2].n2 = (sum19 > 19'(ggxh_pkg::SAT_N2)) ? ggxh_pkg::SAT_N2 : sum19[17:0];

      // denominator (1-v) + v*n2, alongside the first root chain
      omv = ggxh_pkg::ONE_W - {1'b0, side_ff[ST_RA-1].v};
      vn  = 34'(side_ff[ST_RA-1].v) * 34'(side_ff[ST_RA-1].n2);
      side_in[ST_RA].den = 19'(omv) + 19'(vn[33:16]);

      side_in[ST_DV].nzero = ra_link[SC].root == 17'd0;

      // zero scaled direction keeps the unscaled cos/sin
      s = side_ff[ST_NORM-1];
      side_in[ST_NORM].cn = s.nzero ? s.cm : ggxh_pkg::clamp_one(dx_link[DC].quot);
      side_in[ST_NORM].sn = s.nzero ? s.sm : ggxh_pkg::clamp_one(dy_link[DC].quot);
      side_in[ST_NORM].cos2 = (s.den == 19'd0) ? ggxh_pkg::ONE_W
                                               : ggxh_pkg::clamp_one(dc_link[DC].quot);

      ct   = rb_link[SC].root;
      ctsq = 34'(ct) * 34'(ct);
      side_in[ST_ST2].ct  = ct;
      side_in[ST_ST2].st2 = ggxh_pkg::ONE_W - ctsq[32:16];

      s    = side_ff[ST_OUT-1];
      hxp  = 34'(rc_link[SC].root) * 34'(s.cn);
      hyp  = 34'(rc_link[SC].root) * 34'(s.sn);
      hz16 = ggxh_pkg::to_out(s.ct, 1'b0);
      side_in[ST_OUT].hx = ggxh_pkg::to_out(hxp[32:16], s.cneg);
      side_in[ST_OUT].hy = ggxh_pkg::to_out(hyp[32:16], s.sneg);
      side_in[ST_OUT].hz = hz16[14:0];
   end

   assign rsp_valid  = vld_ff[ST_OUT];
   assign rsp_half_x = signed'(side_ff[ST_OUT].hx);
   assign rsp_half_y = signed'(side_ff[ST_OUT].hy);
   assign rsp_half_z = side_ff[ST_OUT].hz;

   a_stall_back: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> req_stall)
      else $error("input taken while result blocked");

   a_pipe_hold: assert property (@(posedge clock) disable iff (reset)
      !pipe_en |=> $stable(vld_ff))
      else $error("pipeline moved during stall");

   a_no_min: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_half_x != 16'sh8000 && rsp_half_y != 16'sh8000))
      else $error("output magnitude past saturation");

endmodule
`default_nettype wire
